FILE: sv/rsk_pkg.sv
package rsk_pkg;

	// Batch capacity, tag width and key width
	localparam int MAX_RECORDS = 64;
	localparam int TAG_BITS    = 48;
	localparam int KEY_BITS    = 16;
	// Fill count must hold MAX_RECORDS itself
	localparam int CNT_W       = $clog2(MAX_RECORDS + 1);

	typedef logic signed [KEY_BITS-1:0] key_t;
	typedef logic [TAG_BITS-1:0]        tag_t;
	typedef logic [CNT_W-1:0]           cnt_t;

	// Controller phases
	typedef enum logic {
		ST_FILL,
		ST_DRAIN
	} state_t;

	// Per-cycle command broadcast to every cell
	typedef struct packed {
		logic ins_en;    // insert the broadcast word this cycle
		logic shift_out; // move every record one cell toward the head
	} cell_ctl_t;

endpackage

FILE: sv/rsk_cell.sv
module rsk_cell (
	input  logic              clk,
	input  rsk_pkg::cell_ctl_t ctl,
	input  logic              occ,
	input  rsk_pkg::key_t     new_key,
	input  rsk_pkg::tag_t     new_tag,
	input  rsk_pkg::key_t     left_key,
	input  rsk_pkg::tag_t     left_tag,
	input  logic              left_gt,
	input  logic              left_open,
	input  rsk_pkg::key_t     right_key,
	input  rsk_pkg::tag_t     right_tag,
	output rsk_pkg::key_t     key,
	output rsk_pkg::tag_t     tag,
	output logic              gt,
	output logic              open
);
	import rsk_pkg::*;

	key_t key_q;
	tag_t tag_q;

	// Strictly greater keeps equal keys in arrival order
	assign gt   = occ && (key_q > new_key);
	assign open = gt || !occ;
	assign key  = key_q;
	assign tag  = tag_q;

	// Payload only: occupancy comes from the fill count
	always_ff @(posedge clk) begin
		if (ctl.shift_out) begin
			key_q <= right_key;
			tag_q <= right_tag;
		end else if (ctl.ins_en) begin
			if (left_gt) begin
				key_q <= left_key;
				tag_q <= left_tag;
			end else if (open && !left_open) begin
				key_q <= new_key;
				tag_q <= new_tag;
			end
		end
	end

endmodule

FILE: sv/record_insertion_sort_by_key_core.sv
// Stable insertion sorter for batches of up to MAX_RECORDS records.
// Input channel (in_valid/in_ready): one word per record, a signed Q8.8
// sort_key, an opaque tag and batch_end. Each accepted word is inserted in
// the same cycle into a row of cells kept in ascending key order; a word
// with a key equal to stored ones lands behind them. One word per cycle is
// taken while filling.
// A word with batch_end set closes the batch: from the next cycle the row
// drains through the output channel (out_valid/out_ready), smallest key
// first, one word per cycle while out_ready is high. out_last marks the
// final word; overflow is high on every word of a batch that lost records.
// The first result appears in the cycle after the closing word. in_ready is
// low during the drain, so a stalled receiver holds the head word and
// back-pressures the input. A word arriving on a full row is dropped and
// sets overflow. Reset empties the row and clears overflow; no clearing pass
// is needed.
module record_insertion_sort_by_key_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [15:0]            sort_key,
	input  logic [rsk_pkg::TAG_BITS-1:0]  tag,
	input  logic                          batch_end,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [15:0]            out_key,
	output logic [rsk_pkg::TAG_BITS-1:0]  out_tag,
	output logic                          out_last,
	output logic                          overflow
);
	import rsk_pkg::*;

	state_t    state_q, state_d;
	cnt_t      count_q, count_d;
	logic      dropped_q, dropped_d;
	cell_ctl_t ctl;
	logic      in_acc, out_acc, full;

	key_t key_w  [MAX_RECORDS];
	tag_t tag_w  [MAX_RECORDS];
	logic gt_w   [MAX_RECORDS];
	logic open_w [MAX_RECORDS];
	logic occ_w  [MAX_RECORDS];

	assign full    = (count_q == cnt_t'(MAX_RECORDS));
	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// Cell row
	genvar i;
	generate
		for (i = 0; i < MAX_RECORDS; i++) begin : g_cell
			key_t l_key, r_key;
			tag_t l_tag, r_tag;
			logic l_gt, l_open;

			assign occ_w[i] = (cnt_t'(i) < count_q);

			if (i == 0) begin : g_head
				assign l_key  = '0;
				assign l_tag  = '0;
				assign l_gt   = 1'b0;
				assign l_open = 1'b0;
			end else begin : g_mid
				assign l_key  = key_w[i-1];
				assign l_tag  = tag_w[i-1];
				assign l_gt   = gt_w[i-1];
				assign l_open = open_w[i-1];
			end

			if (i == MAX_RECORDS - 1) begin : g_tail
				assign r_key = key_w[i];
				assign r_tag = tag_w[i];
			end else begin : g_body
				assign r_key = key_w[i+1];
				assign r_tag = tag_w[i+1];
			end

			rsk_cell u_cell (
				.clk       (clk),
				.ctl       (ctl),
				.occ       (occ_w[i]),
				.new_key   (sort_key),
				.new_tag   (tag),
				.left_key  (l_key),
				.left_tag  (l_tag),
				.left_gt   (l_gt),
				.left_open (l_open),
				.right_key (r_key),
				.right_tag (r_tag),
				.key       (key_w[i]),
				.tag       (tag_w[i]),
				.gt        (gt_w[i]),
				.open      (open_w[i])
			);
		end
	endgenerate

	// Head cell feeds the output directly
	assign out_key  = key_w[0];
	assign out_tag  = tag_w[0];
	assign out_last = (count_q == cnt_t'(1));
	assign overflow = dropped_q;

	// Next state and cell commands
	always_comb begin
		state_d       = state_q;
		count_d       = count_q;
		dropped_d     = dropped_q;
		in_ready      = 1'b0;
		out_valid     = 1'b0;
		ctl.ins_en    = 1'b0;
		ctl.shift_out = 1'b0;
		case (state_q)
			ST_FILL: begin
				in_ready = 1'b1;
				if (in_acc) begin
					if (full) begin
						dropped_d = 1'b1;
					end else begin
						ctl.ins_en = 1'b1;
						count_d    = count_q + cnt_t'(1);
					end
					if (batch_end) begin
						state_d = ST_DRAIN;
					end
				end
			end
			ST_DRAIN: begin
				out_valid = 1'b1;
				if (out_acc) begin
					ctl.shift_out = 1'b1;
					count_d       = count_q - cnt_t'(1);
					if (out_last) begin
						state_d   = ST_FILL;
						dropped_d = 1'b0;
					end
				end
			end
			default: begin
				state_d = ST_FILL;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_FILL;
			count_q   <= '0;
			dropped_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			count_q   <= count_d;
			dropped_q <= dropped_d;
		end
	end

	// Checks
	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= cnt_t'(MAX_RECORDS))
		else $error("fill count above capacity");

	a_drain_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (count_q != '0))
		else $error("draining an empty row");

	a_one_side: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("fill and drain at once");

	a_last_reopens: assert property (@(posedge clk) disable iff (!arst_n)
		(out_acc && out_last) |=> (in_ready && !overflow && count_q == '0))
		else $error("batch not closed after last word");

	a_close_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && batch_end) |=> out_valid)
		else $error("closing word did not start drain");

endmodule
